@@ design/lcdtw_pkg.sv @@
// Shared types, constants and helpers for the character-display text writer.
`timescale 1ns / 1ps
package lcdtw_pkg;

	localparam logic [1:0] FUNC_PRINT   = 2'd0;
	localparam logic [1:0] FUNC_SET_CUR = 2'd1;
	localparam logic [1:0] FUNC_RAW_CMD = 2'd2;

	localparam logic [1:0] CFG_NUM_COLUMNS = 2'd0;
	localparam logic [1:0] CFG_NUM_ROWS    = 2'd1;
	localparam logic [1:0] CFG_LEFT_RIGHT  = 2'd2;
	localparam logic [1:0] CFG_EIGHT_BIT   = 2'd3;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic       RS_COMMAND   = 1'b0;
	localparam logic       RS_DATA      = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
		logic [5:0] cursor_col;
		logic [1:0] cursor_row;
	} item_t;

	typedef struct packed {
		logic       register_select;
		logic [7:0] bus_value;
		logic       is_last;
	} xfer_t;

	typedef struct packed {
		logic [5:0] num_columns;
		logic [2:0] num_rows;
		logic       text_left_to_right;
		logic       eight_bit_bus;
	} cfg_t;

	// One queued request: an optional set-address byte, then an optional data byte.
	typedef struct packed {
		logic       has_addr;
		logic [7:0] addr_byte;
		logic       has_data;
		logic       data_rs;
		logic [7:0] data_byte;
	} entry_t;

	function automatic logic [6:0] row_base(input logic [1:0] line);
		logic [6:0] b;
		case (line)
			2'd0: b = 7'h00;
			2'd1: b = 7'h40;
			2'd2: b = 7'h14;
			2'd3: b = 7'h54;
			default: b = 7'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] addr_byte(input logic [6:0] col, input logic [1:0] line);
		logic [6:0] s;
		s = col + row_base(line);
		return CMD_SET_ADDR | {1'b0, s};
	endfunction

endpackage

@@ design/lcd_text_to_bus_writes_top.sv @@
// Character-display text writer: requests in, bus transfers out.
// A request reaches the queue at its accept edge; its first transfer then loads
// into the output register. Throughput: one transfer per cycle out while xfer_stall
// is low; a request makes zero to four transfers, set by its kind, the cursor and
// the bus width, and is taken every cycle while the two-entry queue has room.
// Reset clears the cursor, the queue and the output valid flag, and loads default config.
`timescale 1ns / 1ps
module lcd_text_to_bus_writes_top #(
	parameter int MAX_COLUMNS = 40,
	parameter int ROW_COUNT   = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lcdtw_pkg::item_t   item,
	output logic               xfer_valid,
	input  logic               xfer_stall,
	output lcdtw_pkg::xfer_t   xfer,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [5:0]         cfg_data
);
	import lcdtw_pkg::*;

	cfg_t   cfg_q;
	entry_t entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   full;
	logic   not_empty;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_columns        <= 6'd16;
			cfg_q.num_rows           <= 3'd2;
			cfg_q.text_left_to_right <= 1'b1;
			cfg_q.eight_bit_bus      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_COLUMNS: cfg_q.num_columns        <= cfg_data;
				CFG_NUM_ROWS:    cfg_q.num_rows           <= cfg_data[2:0];
				CFG_LEFT_RIGHT:  cfg_q.text_left_to_right <= cfg_data[0];
				CFG_EIGHT_BIT:   cfg_q.eight_bit_bus      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign item_stall = full;
	assign accept     = item_valid && !full;

	lcdtw_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.ROW_COUNT  (ROW_COUNT)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.cfg   (cfg_q),
		.push  (push),
		.entry (entry)
	);

	lcdtw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.pop      (pop),
		.full     (full),
		.not_empty(not_empty),
		.head     (head)
	);

	lcdtw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.eight_bit_bus(cfg_q.eight_bit_bus),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.xfer_valid   (xfer_valid),
		.xfer_stall   (xfer_stall),
		.xfer         (xfer)
	);

endmodule

@@ design/lcdtw_front.sv @@
// Front end: accepts requests, tracks the cursor and builds queue entries.
`timescale 1ns / 1ps
module lcdtw_front #(
	parameter int MAX_COLUMNS = 40,
	parameter int ROW_COUNT   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  lcdtw_pkg::item_t    item,
	input  lcdtw_pkg::cfg_t     cfg,
	output logic                push,
	output lcdtw_pkg::entry_t   entry
);
	import lcdtw_pkg::*;

	logic [6:0] col_q;
	logic [1:0] line_q;
	logic [6:0] cols_eff;
	logic [2:0] rows_eff;
	logic [6:0] col_n;
	logic [1:0] line_n;
	logic [2:0] line_inc;
	logic [2:0] row_req;
	entry_t     ent;
	logic       upd;

	always_comb begin
		cols_eff = {1'b0, cfg.num_columns};
		if (cols_eff == 7'd0) begin
			cols_eff = 7'd1;
		end
		if (cols_eff > 7'(MAX_COLUMNS)) begin
			cols_eff = 7'(MAX_COLUMNS);
		end
		rows_eff = cfg.num_rows;
		if (rows_eff == 3'd0) begin
			rows_eff = 3'd1;
		end
		if (rows_eff > 3'(ROW_COUNT)) begin
			rows_eff = 3'(ROW_COUNT);
		end
	end

	always_comb begin
		col_n    = col_q;
		line_n   = line_q;
		upd      = 1'b0;
		ent      = '0;
		line_inc = {1'b0, line_q} + 3'd1;
		if (line_inc >= rows_eff) begin
			line_inc = rows_eff - 3'd1;
		end
		row_req = {1'b0, item.cursor_row};
		if (row_req >= rows_eff) begin
			row_req = rows_eff - 3'd1;
		end
		case (item.func)
			FUNC_PRINT: begin
				upd = 1'b1;
				// A newline, or a character written past the edge, starts the next line (on the last row, that row again).
				if (item.char_code == CHAR_NEWLINE || col_q >= cols_eff) begin
					line_n        = line_inc[1:0];
					col_n         = cfg.text_left_to_right ? 7'd0 : cols_eff - 7'd1;
					ent.has_addr  = 1'b1;
					ent.addr_byte = addr_byte(col_n, line_n);
				end
				if (item.char_code != CHAR_NEWLINE) begin
					ent.has_data  = 1'b1;
					ent.data_rs   = RS_DATA;
					ent.data_byte = item.char_code;
					col_n = cfg.text_left_to_right ? col_n + 7'd1 : col_n - 7'd1;
				end
			end
			FUNC_SET_CUR: begin
				upd           = 1'b1;
				line_n        = row_req[1:0];
				col_n         = {1'b0, item.cursor_col};
				ent.has_addr  = 1'b1;
				ent.addr_byte = addr_byte(col_n, line_n);
			end
			FUNC_RAW_CMD: begin
				ent.has_data  = 1'b1;
				ent.data_rs   = RS_COMMAND;
				ent.data_byte = item.char_code;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (accept && upd) begin
			col_q  <= col_n;
			line_q <= line_n;
		end
	end

	assign push  = accept && (ent.has_addr || ent.has_data);
	assign entry = ent;

endmodule

@@ design/lcdtw_queue.sv @@
// Two-entry queue between the front end and the bus sequencer.
`timescale 1ns / 1ps
module lcdtw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lcdtw_pkg::entry_t   wr_entry,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output lcdtw_pkg::entry_t   head
);
	import lcdtw_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

endmodule

@@ design/lcdtw_back.sv @@
// Bus sequencer: splits queued bytes into transfers and holds the output register.
`timescale 1ns / 1ps
module lcdtw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                eight_bit_bus,
	input  logic                not_empty,
	input  lcdtw_pkg::entry_t   head,
	output logic                pop,
	output logic                xfer_valid,
	input  logic                xfer_stall,
	output lcdtw_pkg::xfer_t    xfer
);
	import lcdtw_pkg::*;

	logic       sel_data_q;
	logic       low_nib_q;
	logic       valid_q;
	xfer_t      xfer_q;
	logic       load;
	logic       cur_is_addr;
	logic [7:0] cur_byte;
	logic       byte_done;
	logic       last;

	assign load        = not_empty && (!valid_q || !xfer_stall);
	assign cur_is_addr = head.has_addr && !sel_data_q;
	assign cur_byte    = cur_is_addr ? head.addr_byte : head.data_byte;
	assign byte_done   = eight_bit_bus || low_nib_q;
	assign last        = byte_done && (!cur_is_addr || !head.has_data);
	assign pop         = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_data_q <= 1'b0;
			low_nib_q  <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				if (byte_done) begin
					low_nib_q  <= 1'b0;
					sel_data_q <= !last;
				end else begin
					low_nib_q <= 1'b1;
				end
			end else if (!xfer_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			xfer_q.register_select <= cur_is_addr ? RS_COMMAND : head.data_rs;
			if (eight_bit_bus) begin
				xfer_q.bus_value <= cur_byte;
			end else if (low_nib_q) begin
				xfer_q.bus_value <= {4'd0, cur_byte[3:0]};
			end else begin
				xfer_q.bus_value <= {4'd0, cur_byte[7:4]};
			end
			xfer_q.is_last <= last;
		end
	end

	assign xfer_valid = valid_q;
	assign xfer       = xfer_q;

endmodule
